@@ sv/jbic_pkg.sv @@
// Shared types and codes of the integer bytecode core.
package jbic_pkg;

   // Instruction encodings
   localparam logic [7:0] OP_ICONST_M1 = 8'h02;
   localparam logic [7:0] OP_ICONST_5  = 8'h08;
   localparam logic [7:0] OP_BIPUSH    = 8'h10;
   localparam logic [7:0] OP_ILOAD     = 8'h15;
   localparam logic [7:0] OP_ILOAD_0   = 8'h1a;
   localparam logic [7:0] OP_ILOAD_3   = 8'h1d;
   localparam logic [7:0] OP_ALOAD_0   = 8'h2a;
   localparam logic [7:0] OP_ALOAD_3   = 8'h2d;
   localparam logic [7:0] OP_ISTORE    = 8'h36;
   localparam logic [7:0] OP_ISTORE_0  = 8'h3b;
   localparam logic [7:0] OP_ISTORE_3  = 8'h3e;
   localparam logic [7:0] OP_ASTORE_0  = 8'h4b;
   localparam logic [7:0] OP_ASTORE_3  = 8'h4e;
   localparam logic [7:0] OP_DUP       = 8'h59;
   localparam logic [7:0] OP_IADD      = 8'h60;
   localparam logic [7:0] OP_ISUB      = 8'h64;
   localparam logic [7:0] OP_IMUL      = 8'h68;
   localparam logic [7:0] OP_IDIV      = 8'h6c;
   localparam logic [7:0] OP_IINC      = 8'h84;
   localparam logic [7:0] OP_IF_ICMPEQ = 8'h9f;
   localparam logic [7:0] OP_IF_ICMPNE = 8'ha0;
   localparam logic [7:0] OP_IF_ICMPLT = 8'ha1;
   localparam logic [7:0] OP_IF_ICMPGE = 8'ha2;
   localparam logic [7:0] OP_IF_ICMPGT = 8'ha3;
   localparam logic [7:0] OP_IF_ICMPLE = 8'ha4;
   localparam logic [7:0] OP_GOTO      = 8'ha7;
   localparam logic [7:0] OP_IRETURN   = 8'hac;
   localparam logic [7:0] OP_RETURN    = 8'hb1;

   // Status codes
   localparam logic [2:0] STAT_OK      = 3'd0;
   localparam logic [2:0] STAT_RET     = 3'd1;
   localparam logic [2:0] STAT_RETVAL  = 3'd2;
   localparam logic [2:0] STAT_DIVZERO = 3'd3;
   localparam logic [2:0] STAT_UNSUP   = 3'd4;
   localparam logic [2:0] STAT_RANGE   = 3'd5;

   // Configuration register indexes
   localparam logic CSR_LOCALS_IN_USE = 1'b0;
   localparam logic CSR_STACK_LIMIT   = 1'b1;

   typedef struct packed {
      logic [7:0] opcode;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
   } req_type;

   typedef struct packed {
      logic [15:0]        next_pc;
      logic signed [31:0] top_value;
      logic [6:0]         depth;
      logic [2:0]         status;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_DIV,
      S_POP2,
      S_OUT
   } state_type;

endpackage

@@ sv/jbic_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module jbic_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ sv/jbic_div.sv @@
// Iterative signed divider, truncating toward zero, one quotient bit per cycle.
module jbic_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   logic        busy_ff, done_ff, neg_ff;
   logic [4:0]  cnt_ff;
   logic [32:0] rem_ff;
   logic [31:0] quo_ff, dvs_ff;
   logic [32:0] rem_sh, diff;

   // shift in the next dividend bit and try a subtract
   assign rem_sh = {rem_ff[31:0], quo_ff[31]};
   assign diff   = rem_sh - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= dividend[31] ? 32'd0 - dividend : dividend;
            dvs_ff  <= divisor[31] ? 32'd0 - divisor : divisor;
            neg_ff  <= dividend[31] ^ divisor[31];
         end else if (busy_ff) begin
            if (!diff[32]) begin
               rem_ff <= diff;
               quo_ff <= {quo_ff[30:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[30:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? 32'd0 - quo_ff : quo_ff;
endmodule

@@ sv/java_bytecode_integer_core.sv @@
// Top level of the integer bytecode core: sequencer, stack and local stores.
//
// Executes one instruction per item on an operand stack and a local-variable
// store, both held in synchronous RAMs with registered read data; the top of
// stack is kept in a register. Most instructions are accepted with the RAM
// reads, then executed and written back. if_icmp* adds a pop state, since the
// new top of stack needs a second read of the single stack read port. idiv
// waits for the bit-serial divider (32 steps). Locals read as zero until
// written, tracked by one valid bit per slot, so no clearing pass follows reset.
// A result that waits in the output register does not stop the next item starting.
module java_bytecode_integer_core
   import jbic_pkg::*;
#(
   parameter int STACK_DEPTH = 64,
   parameter int LOCAL_SLOTS = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_we,
   input  logic    csr_index,
   input  logic [8:0] csr_wdata
);
   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int LAW = $clog2(LOCAL_SLOTS);

   state_type state_ff, state_in;

   logic [8:0]  locals_in_use_ff;
   logic [6:0]  stack_limit_ff;
   logic [15:0] pc_ff;
   logic [SPW-1:0] sp_ff;
   logic [31:0] tos_ff;
   logic        halted_ff;
   logic [LOCAL_SLOTS-1:0] lvalid_ff;

   logic [7:0]  op_ff, b1_ff, b2_ff;
   logic        lv_ff;
   logic [15:0] br_pc_ff;
   rsp_type     rsp_ff, res_ff;
   logic        rsp_valid_ff;

   logic        accept, slot_free;
   logic [31:0] stk_rd, loc_rd, lval;
   logic [SAW-1:0] stk_raddr;
   logic [7:0]  req_lidx, lidx;

   // commit bundle
   logic        cm_valid, cm_upd, cm_halt, div_start, go_div, go_pop2;
   logic [2:0]  cm_stat;
   logic [15:0] cm_pc;
   logic [SPW-1:0] cm_sp;
   logic [31:0] cm_tos;
   rsp_type     cm_rsp;
   logic        swe, lwe;
   logic [SAW-1:0] swaddr;
   logic [31:0] swdata, lwdata;
   logic        div_done;
   logic [31:0] div_q;

   // local index coded in the instruction
   function automatic logic [7:0] local_index(input logic [7:0] op, input logic [7:0] b1);
      logic [7:0] idx;
      idx = b1;
      case (op) inside
         [OP_ILOAD_0:OP_ILOAD_3], [OP_ALOAD_0:OP_ALOAD_3]: idx = {6'd0, op[1:0] ^ 2'd2};
         [OP_ISTORE_0:OP_ISTORE_3], [OP_ASTORE_0:OP_ASTORE_3]:
            idx = {6'd0, op[1:0] + 2'd1};
         default: idx = b1;
      endcase
      return idx;
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_lidx  = local_index(req_data.opcode, req_data.first_byte);
   assign lidx      = local_index(op_ff, b1_ff);
   assign lval      = lv_ff ? loc_rd : 32'd0;
   assign stk_raddr = (state_ff == S_IDLE) ? SAW'(sp_ff - SPW'(2)) : SAW'(sp_ff - SPW'(3));

   jbic_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .we(swe), .waddr(swaddr), .wdata(swdata),
      .raddr(stk_raddr), .rdata(stk_rd)
   );

   jbic_ram #(.WIDTH(32), .DEPTH(LOCAL_SLOTS)) u_locals (
      .clock(clock), .we(lwe), .waddr(lidx[LAW-1:0]), .wdata(lwdata),
      .raddr(req_lidx[LAW-1:0]), .rdata(loc_rd)
   );

   jbic_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(stk_rd), .divisor(tos_ff), .done(div_done), .quotient(div_q)
   );

   // execute and commit
   always_comb begin
      logic        push, bad_loc, cond;
      logic [31:0] pv, sb, r;
      logic [15:0] off;
      push = 1'b0;  pv = 32'd0;  r = 32'd0;  cond = 1'b0;
      cm_valid = 1'b0;  cm_halt = 1'b0;  div_start = 1'b0;
      go_div = 1'b0;  go_pop2 = 1'b0;
      cm_stat = STAT_OK;  cm_pc = pc_ff;  cm_sp = sp_ff;  cm_tos = tos_ff;
      swe = 1'b0;  swaddr = SAW'(sp_ff - SPW'(2));  swdata = 32'd0;
      lwe = 1'b0;  lwdata = tos_ff;
      off = {b1_ff, b2_ff};
      sb  = {{24{b2_ff[7]}}, b2_ff};
      bad_loc = (32'(lidx) >= 32'(locals_in_use_ff)) || (32'(lidx) >= LOCAL_SLOTS);
      case (state_ff)
         S_EXEC: begin
            cm_valid = 1'b1;
            if (halted_ff) begin
               cm_stat = STAT_RET;
            end else begin
               case (op_ff) inside
                  [OP_ICONST_M1:OP_ICONST_5]: begin
                     push = 1'b1;  pv = {24'd0, op_ff} - 32'd3;  cm_pc = pc_ff + 16'd1;
                  end
                  OP_BIPUSH: begin
                     push = 1'b1;  pv = {{24{b1_ff[7]}}, b1_ff};  cm_pc = pc_ff + 16'd2;
                  end
                  OP_ILOAD, [OP_ILOAD_0:OP_ILOAD_3], [OP_ALOAD_0:OP_ALOAD_3]: begin
                     cm_pc = pc_ff + ((op_ff == OP_ILOAD) ? 16'd2 : 16'd1);
                     if (bad_loc) cm_stat = STAT_RANGE;
                     else begin
                        push = 1'b1;  pv = lval;
                     end
                  end
                  OP_ISTORE, [OP_ISTORE_0:OP_ISTORE_3], [OP_ASTORE_0:OP_ASTORE_3]: begin
                     cm_pc = pc_ff + ((op_ff == OP_ISTORE) ? 16'd2 : 16'd1);
                     if (bad_loc || sp_ff == '0) cm_stat = STAT_RANGE;
                     else begin
                        lwe = 1'b1;  lwdata = tos_ff;
                        cm_sp = sp_ff - SPW'(1);  cm_tos = stk_rd;
                     end
                  end
                  OP_DUP: begin
                     cm_pc = pc_ff + 16'd1;
                     if (sp_ff == '0) cm_stat = STAT_RANGE;
                     else begin
                        push = 1'b1;  pv = tos_ff;
                     end
                  end
                  OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV: begin
                     cm_pc = pc_ff + 16'd1;
                     if (32'(sp_ff) < 2) cm_stat = STAT_RANGE;
                     else if (op_ff == OP_IDIV) begin
                        if (tos_ff == 32'd0) cm_stat = STAT_DIVZERO;
                        else begin
                           cm_valid = 1'b0;  div_start = 1'b1;  go_div = 1'b1;
                        end
                     end else begin
                        case (op_ff)
                           OP_IADD: r = stk_rd + tos_ff;
                           OP_ISUB: r = stk_rd - tos_ff;
                           default: r = stk_rd * tos_ff;
                        endcase
                        swe = 1'b1;  swdata = r;
                        cm_sp = sp_ff - SPW'(1);  cm_tos = r;
                     end
                  end
                  OP_IINC: begin
                     cm_pc = pc_ff + 16'd3;
                     if (32'(b1_ff) >= 32'(locals_in_use_ff) || 32'(b1_ff) >= LOCAL_SLOTS)
                        cm_stat = STAT_RANGE;
                     else begin
                        lwe = 1'b1;  lwdata = lval + sb;
                     end
                  end
                  [OP_IF_ICMPEQ:OP_IF_ICMPLE]: begin
                     if (32'(sp_ff) < 2) cm_stat = STAT_RANGE;
                     else begin
                        case (op_ff)
                           OP_IF_ICMPEQ: cond = stk_rd == tos_ff;
                           OP_IF_ICMPNE: cond = stk_rd != tos_ff;
                           OP_IF_ICMPLT: cond = $signed(stk_rd) <  $signed(tos_ff);
                           OP_IF_ICMPGE: cond = $signed(stk_rd) >= $signed(tos_ff);
                           OP_IF_ICMPGT: cond = $signed(stk_rd) >  $signed(tos_ff);
                           default:      cond = $signed(stk_rd) <= $signed(tos_ff);
                        endcase
                        cm_pc = cond ? pc_ff + off : pc_ff + 16'd3;
                        cm_valid = 1'b0;  go_pop2 = 1'b1;
                     end
                  end
                  OP_GOTO: cm_pc = pc_ff + off;
                  OP_IRETURN: begin
                     if (sp_ff == '0) cm_stat = STAT_RANGE;
                     else begin
                        cm_stat = STAT_RETVAL;  cm_halt = 1'b1;
                     end
                  end
                  OP_RETURN: begin
                     cm_stat = STAT_RET;  cm_halt = 1'b1;
                  end
                  default: cm_stat = STAT_UNSUP;
               endcase
               // common push with limit check
               if (push) begin
                  if (32'(sp_ff) >= 32'(stack_limit_ff) || 32'(sp_ff) >= STACK_DEPTH)
                     cm_stat = STAT_RANGE;
                  else begin
                     swe = 1'b1;  swaddr = SAW'(sp_ff);  swdata = pv;
                     cm_sp = sp_ff + SPW'(1);  cm_tos = pv;
                  end
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               cm_valid = 1'b1;  cm_pc = pc_ff + 16'd1;
               swe = 1'b1;  swdata = div_q;
               cm_sp = sp_ff - SPW'(1);  cm_tos = div_q;
            end
         end
         S_POP2: begin
            cm_valid = 1'b1;  cm_pc = br_pc_ff;
            cm_sp = sp_ff - SPW'(2);  cm_tos = stk_rd;
         end
         default: ;
      endcase
      // errors leave state alone
      cm_upd = (cm_stat == STAT_OK) || (cm_stat == STAT_RET) || (cm_stat == STAT_RETVAL);
      if (!cm_upd) begin
         swe = 1'b0;  lwe = 1'b0;
         cm_pc = pc_ff;  cm_sp = sp_ff;  cm_tos = tos_ff;
      end
      cm_rsp.next_pc   = cm_pc;
      cm_rsp.top_value = (cm_sp == '0) ? 32'sd0 : $signed(cm_tos);
      cm_rsp.depth     = 7'(cm_sp);
      cm_rsp.status    = cm_stat;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) state_in = S_EXEC;
         S_EXEC, S_DIV, S_POP2: begin
            if (go_div) state_in = S_DIV;
            else if (go_pop2) state_in = S_POP2;
            else if (cm_valid) state_in = slot_free ? S_IDLE : S_OUT;
         end
         S_OUT: if (slot_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         locals_in_use_ff <= 9'd256;
         stack_limit_ff   <= 7'd64;
         pc_ff            <= '0;
         sp_ff            <= '0;
         halted_ff        <= 1'b0;
         lvalid_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_LOCALS_IN_USE: locals_in_use_ff <= csr_wdata;
               default:           stack_limit_ff   <= csr_wdata[6:0];
            endcase
         end
         if (cm_valid && cm_upd) begin
            pc_ff <= cm_pc;
            sp_ff <= cm_sp;
            if (cm_halt) halted_ff <= 1'b1;
         end
         if (lwe) lvalid_ff[lidx[LAW-1:0]] <= 1'b1;
         // output register
         if (cm_valid && slot_free) rsp_valid_ff <= 1'b1;
         else if (state_ff == S_OUT && slot_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_data.opcode;
         b1_ff <= req_data.first_byte;
         b2_ff <= req_data.second_byte;
         lv_ff <= lvalid_ff[req_lidx[LAW-1:0]];
      end
      if (go_pop2) br_pc_ff <= cm_pc;
      if (cm_valid && cm_upd) tos_ff <= cm_tos;
      if (cm_valid) res_ff <= cm_rsp;
      if (cm_valid && slot_free) rsp_ff <= cm_rsp;
      else if (state_ff == S_OUT && slot_free) rsp_ff <= res_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      32'(sp_ff) <= STACK_DEPTH) else $error("stack pointer beyond depth");
   a_halt_pc: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> $stable(pc_ff) && halted_ff) else $error("pc moved while halted");
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV) else $error("divider done outside divide");
   a_swe_state: assert property (@(posedge clock) disable iff (reset)
      swe |-> (state_ff == S_EXEC || state_ff == S_DIV)) else $error("stray stack write");
endmodule
